>>> hw/rtl/acl_pkg.sv
package acl_pkg;

  localparam int MAX_RULES = 64;
  localparam int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W     = $clog2(MAX_RULES + 1);
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  localparam logic [5:0] PLEN_MAX = 6'd32;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] ST_STORED  = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_ANSWER  = 2'd2;
  localparam logic [1:0] ST_CLEARED = 2'd3;

  typedef enum logic [1:0] {
    OP_APPEND,
    OP_QUERY,
    OP_CLEAR
  } acl_op_t;

  typedef struct packed {
    acl_op_t     op;
    logic [31:0] addr;
    logic [5:0]  plen;
    logic        allow;
  } acl_item_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [5:0]  plen;
    logic        allow;
  } acl_rule_t;

  function automatic logic [31:0] prefix_mask(input logic [5:0] plen);
    logic [31:0] m;
    m = '0;
    if (plen != 6'd0) begin
      m = 32'hFFFF_FFFF << (PLEN_MAX - plen);
    end
    return m;
  endfunction

endpackage

>>> hw/rtl/ipv4_first_match_acl.sv
// First-match IPv4 prefix ACL. Each input item is an append (store a rule at the
// end of the table, or report the table full), a query (first stored rule whose top
// prefix_len bits equal the address decides; otherwise the default verdict applies),
// or a clear. Each item gives exactly one result item. Items enter a four-deep queue
// and are carried out by a back end that holds the rule memory: an append or clear
// is answered directly; a query scans the single-read-port rule memory one entry
// per cycle with a registered read, up to the first hit or the end of the table.
// Configuration (default verdict, reset allow) is always ready and must be written
// while the block is idle.
module ipv4_first_match_acl
  import acl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_default_verdict,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_address,
  input  logic [5:0]  in_prefix_len,
  input  logic        in_allow_rule,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_allowed,
  output logic        out_matched,
  output logic [5:0]  out_match_index
);

  logic      q_full;
  logic      q_push;
  acl_item_t q_in_item;
  logic      q_pop;
  logic      q_valid;
  acl_item_t q_out_item;

  assign cfg_ready = 1'b1;

  acl_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_address    (in_address),
    .in_prefix_len (in_prefix_len),
    .in_allow_rule (in_allow_rule),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_in_item)
  );

  acl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_out_item)
  );

  acl_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_valid),
    .cfg_verdict     (cfg_default_verdict),
    .q_valid         (q_valid),
    .q_item          (q_out_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_allowed     (out_allowed),
    .out_matched     (out_matched),
    .out_match_index (out_match_index)
  );

endmodule

>>> hw/rtl/acl_front.sv
module acl_front
  import acl_pkg::*;
(
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_address,
  input  logic [5:0]  in_prefix_len,
  input  logic        in_allow_rule,
  input  logic        q_full,
  output logic        q_push,
  output acl_item_t   q_item
);

  // unknown command code is treated as a query
  always_comb begin
    q_item.addr  = in_address;
    q_item.allow = in_allow_rule;
    q_item.plen  = (in_prefix_len > PLEN_MAX) ? PLEN_MAX : in_prefix_len;
    case (in_command)
      CMD_APPEND: q_item.op = OP_APPEND;
      CMD_CLEAR:  q_item.op = OP_CLEAR;
      CMD_QUERY:  q_item.op = OP_QUERY;
      default:    q_item.op = OP_QUERY;
    endcase
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

endmodule

>>> hw/rtl/acl_queue.sv
module acl_queue
  import acl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  acl_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      pop_valid,
  output acl_item_t pop_item
);

  acl_item_t             slot_r [QDEPTH];
  logic [QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]       cnt_r, cnt_nxt;
  logic                  do_pop;

  assign full      = (cnt_r == (QPTR_W + 1)'(QDEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_item  = slot_r[rd_ptr_r];
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> hw/rtl/acl_back.sv
module acl_back
  import acl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_verdict,
  input  logic        q_valid,
  input  acl_item_t   q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_allowed,
  output logic        out_matched,
  output logic [5:0]  out_match_index
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  acl_rule_t          rule_mem [MAX_RULES];
  acl_rule_t          ent_r;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic [31:0]        qaddr_r, qaddr_nxt;
  logic               verdict_r;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         status_r, status_nxt;
  logic               allowed_r, allowed_nxt;
  logic               matched_r, matched_nxt;
  logic [5:0]         index_r, index_nxt;

  logic               out_free;
  logic               wr_en;
  logic               rd_en;
  logic               hit;
  logic               full;

  assign out_free = !out_valid_r || out_ready;
  assign full     = (count_r == CNT_W'(MAX_RULES));
  assign hit      = cmp_vld_r && (((ent_r.addr ^ qaddr_r) & prefix_mask(ent_r.plen)) == '0);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_idx_nxt   = cmp_idx_r;
    qaddr_nxt     = qaddr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    allowed_nxt   = allowed_r;
    matched_nxt   = matched_r;
    index_nxt     = index_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          case (q_item.op)
            OP_QUERY: begin
              q_pop       = 1'b1;
              qaddr_nxt   = q_item.addr;
              rd_idx_nxt  = '0;
              cmp_vld_nxt = 1'b0;
              state_nxt   = S_SCAN;
            end
            OP_APPEND: begin
              if (out_free) begin
                q_pop         = 1'b1;
                wr_en         = !full;
                count_nxt     = full ? count_r : count_r + 1'b1;
                out_valid_nxt = 1'b1;
                status_nxt    = full ? ST_FULL : ST_STORED;
                allowed_nxt   = 1'b0;
                matched_nxt   = 1'b0;
                index_nxt     = '0;
              end
            end
            default: begin
              if (out_free) begin
                q_pop         = 1'b1;
                count_nxt     = '0;
                out_valid_nxt = 1'b1;
                status_nxt    = ST_CLEARED;
                allowed_nxt   = 1'b0;
                matched_nxt   = 1'b0;
                index_nxt     = '0;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        if (hit || (!cmp_vld_r && (rd_idx_r >= count_r))) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            status_nxt    = ST_ANSWER;
            allowed_nxt   = hit ? ent_r.allow : verdict_r;
            matched_nxt   = hit;
            index_nxt     = hit ? 6'(cmp_idx_r) : 6'd0;
            cmp_vld_nxt   = 1'b0;
            state_nxt     = S_IDLE;
          end
        end else begin
          rd_en       = (rd_idx_r < count_r);
          cmp_vld_nxt = rd_en;
          cmp_idx_nxt = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt  = rd_en ? rd_idx_r + 1'b1 : rd_idx_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_idx_r    <= '0;
      cmp_vld_r   <= 1'b0;
      verdict_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        verdict_r <= cfg_verdict;
      end
    end
    cmp_idx_r <= cmp_idx_nxt;
    qaddr_r   <= qaddr_nxt;
    status_r  <= status_nxt;
    allowed_r <= allowed_nxt;
    matched_r <= matched_nxt;
    index_r   <= index_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rule_mem[count_r[IDX_W-1:0]] <= '{addr: q_item.addr, plen: q_item.plen,
                                        allow: q_item.allow};
    end
    if (rd_en) begin
      ent_r <= rule_mem[rd_idx_r[IDX_W-1:0]];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_allowed     = allowed_r;
  assign out_matched     = matched_r;
  assign out_match_index = index_r;

endmodule

>>> hw/rtl/acl_checker.sv
module acl_checker
  import acl_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic        out_allowed,
  input logic        out_matched,
  input logic [5:0]  out_match_index
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_allowed) && $stable(out_matched) && $stable(out_match_index))
    else $error("result changed while stalled");

  a_non_query_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_ANSWER) |->
      !out_allowed && !out_matched && (out_match_index == 6'd0))
    else $error("non-query result carries verdict fields");

  a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_matched |-> (out_match_index == 6'd0))
    else $error("index set without a match");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ipv4_first_match_acl acl_checker u_acl_checker (.*);

>>> verif/ipv4_first_match_acl_test.sv
`timescale 1ns / 100ps

module ipv4_first_match_acl_test;
  import acl_pkg::*;

  localparam logic [1:0] CMD_QUERY_ALT = 2'd3;
  localparam int RULE_SLOTS = MAX_RULES;

  typedef struct packed {
    logic [1:0] status;
    logic       allowed;
    logic       matched;
    logic [5:0] index;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_default_verdict = 1'b0;
  logic        in_valid = 1'b0;
  logic [1:0]  in_command = CMD_APPEND;
  logic [31:0] in_address = '0;
  logic [5:0]  in_prefix_len = '0;
  logic        in_allow_rule = 1'b0;
  logic        out_ready = 1'b0;
  logic        cfg_ready;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  out_status;
  logic        out_allowed;
  logic        out_matched;
  logic [5:0]  out_match_index;

  ipv4_first_match_acl uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_default_verdict (cfg_default_verdict),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_address          (in_address),
    .in_prefix_len       (in_prefix_len),
    .in_allow_rule       (in_allow_rule),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_allowed         (out_allowed),
    .out_matched         (out_matched),
    .out_match_index     (out_match_index)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // rule table mirror
  logic [31:0] rule_addr_m  [RULE_SLOTS];
  logic [5:0]  rule_len_m   [RULE_SLOTS];
  logic        rule_allow_m [RULE_SLOTS];
  int unsigned rule_total = 0;
  logic        verdict_default = 1'b1;

  verdict_t expected_verdicts[$];
  int fail_count = 0;
  int items_sent = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int stall_left = 0;

  function automatic logic [31:0] top_bits_mask(input logic [5:0] len);
    logic [31:0] m;
    m = '0;
    for (int b = 0; b < 32; b++) begin
      if (b < len) m[31 - b] = 1'b1;
    end
    return m;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  task automatic predict_verdict(input logic [1:0] cmd, input logic [31:0] addr,
                                 input logic [5:0] len, input logic allow);
    verdict_t v;
    v = '0;
    case (cmd)
      CMD_APPEND: begin
        if (rule_total >= RULE_SLOTS) begin
          v.status = ST_FULL;
        end else begin
          rule_addr_m[rule_total]  = addr;
          rule_len_m[rule_total]   = (len > PLEN_MAX) ? PLEN_MAX : len;
          rule_allow_m[rule_total] = allow;
          rule_total++;
          v.status = ST_STORED;
        end
      end
      CMD_CLEAR: begin
        rule_total = 0;
        v.status = ST_CLEARED;
      end
      default: begin
        v.status  = ST_ANSWER;
        v.allowed = verdict_default;
        for (int i = 0; i < rule_total; i++) begin
          if (((rule_addr_m[i] ^ addr) & top_bits_mask(rule_len_m[i])) == 32'd0) begin
            v.matched = 1'b1;
            v.index   = 6'(i);
            v.allowed = rule_allow_m[i];
            break;
          end
        end
      end
    endcase
    expected_verdicts = {expected_verdicts, v};
  endtask

  task automatic send_item(input logic [1:0] cmd, input logic [31:0] addr,
                           input logic [5:0] len, input logic allow);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_address    <= addr;
    in_prefix_len <= len;
    in_allow_rule <= allow;
    do @(posedge clk); while (!in_ready);
    predict_verdict(cmd, addr, len, allow);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic set_default_verdict(input logic v);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_default_verdict <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    verdict_default = v;
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        $error("unexpected result item, status %0d", out_status);
        fail_count++;
      end else begin
        want = expected_verdicts.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          fail_count++;
        end
        if (out_allowed !== want.allowed) begin
          $error("allowed: expected %0d, actual %0d", want.allowed, out_allowed);
          fail_count++;
        end
        if (out_matched !== want.matched) begin
          $error("matched: expected %0d, actual %0d", want.matched, out_matched);
          fail_count++;
        end
        if (out_match_index !== want.index) begin
          $error("match_index: expected %0d, actual %0d", want.index, out_match_index);
          fail_count++;
        end
      end
    end
    if (rx_steady || stall_left == 0) begin
      out_ready <= 1'b1;
      if (!rx_steady && $urandom_range(0, 99) < 30) stall_left = pick_gap();
    end else begin
      out_ready <= 1'b0;
      stall_left--;
    end
  end

  task automatic test_empty_table();
    send_item(CMD_QUERY, 32'h0000_0000, 6'd0, 1'b0);
    set_default_verdict(1'b0);
    send_item(CMD_QUERY, 32'hFFFF_FFFF, 6'd63, 1'b1);
    send_item(CMD_QUERY_ALT, 32'h8000_0001, 6'd0, 1'b0);
    set_default_verdict(1'b1);
    send_item(CMD_QUERY, 32'h0A00_0001, 6'd32, 1'b1);
  endtask

  task automatic test_prefix_rules();
    send_item(CMD_APPEND, 32'h0A00_0000, 6'd8, 1'b0);
    send_item(CMD_APPEND, 32'hFFFF_FFFF, 6'd32, 1'b1);
    send_item(CMD_APPEND, 32'hC0A8_0101, 6'd40, 1'b1);
    send_item(CMD_APPEND, 32'h1234_5678, 6'd63, 1'b0);
    send_item(CMD_APPEND, 32'h0000_0000, 6'd0, 1'b1);
    send_item(CMD_QUERY, 32'h0AFF_FFFF, 6'd0, 1'b0);
    send_item(CMD_QUERY, 32'h0B00_0000, 6'd0, 1'b0);
    send_item(CMD_QUERY, 32'hFFFF_FFFF, 6'd0, 1'b0);
    send_item(CMD_QUERY, 32'hFFFF_FFFE, 6'd0, 1'b0);
    send_item(CMD_QUERY, 32'hC0A8_0101, 6'd0, 1'b0);
    send_item(CMD_QUERY, 32'hC0A8_0100, 6'd0, 1'b0);
    send_item(CMD_QUERY_ALT, 32'h1234_5678, 6'd0, 1'b0);
    send_item(CMD_QUERY, 32'h1234_5679, 6'd0, 1'b0);
    send_item(CMD_CLEAR, 32'hFFFF_FFFF, 6'd63, 1'b1);
    send_item(CMD_QUERY, 32'h0A00_0000, 6'd0, 1'b0);
    send_item(CMD_APPEND, 32'h8000_0000, 6'd1, 1'b0);
    send_item(CMD_QUERY_ALT, 32'hFFFF_FFFF, 6'd0, 1'b0);
    send_item(CMD_QUERY, 32'h7FFF_FFFF, 6'd0, 1'b0);
    send_item(CMD_CLEAR, 32'h0000_0000, 6'd0, 1'b0);
  endtask

  task automatic test_full_table();
    logic [31:0] first_addr;
    logic [31:0] last_addr;
    send_item(CMD_CLEAR, $urandom, 6'd0, 1'b0);
    for (int i = 0; i < RULE_SLOTS; i++) begin
      send_item(CMD_APPEND, $urandom, 6'($urandom_range(16, 32)), 1'($urandom_range(0, 1)));
    end
    first_addr = rule_addr_m[0];
    last_addr  = rule_addr_m[RULE_SLOTS - 1];
    send_item(CMD_QUERY, last_addr, 6'd0, 1'b0);
    drain_results();
    send_item(CMD_APPEND, 32'hFFFF_FFFF, 6'd63, 1'b1);
    send_item(CMD_APPEND, 32'h0000_0000, 6'd0, 1'b0);
    send_item(CMD_QUERY_ALT, first_addr, 6'd0, 1'b0);
    send_item(CMD_CLEAR, 32'h0000_0000, 6'd0, 1'b0);
    send_item(CMD_APPEND, last_addr, 6'd32, 1'b0);
    send_item(CMD_QUERY, last_addr, 6'd0, 1'b0);
  endtask

  task automatic test_random_traffic();
    int target;
    int n_rules;
    int unsigned pick;
    logic [31:0] addr;
    for (int phase = 0; phase < 4; phase++) begin
      set_default_verdict((phase == 2) ? 1'($urandom_range(0, 1)) : 1'(phase % 2));
      target = items_sent + 100;
      while (items_sent < target) begin
        tx_steady = ($urandom_range(0, 7) == 0);
        rx_steady = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 9) < 7) begin
          if ($urandom_range(0, 1)) begin
            send_item(CMD_CLEAR, $urandom, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
          end
          n_rules = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 12);
          repeat (n_rules) begin
            send_item(CMD_APPEND, $urandom,
                      6'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                                     : $urandom_range(12, 32)),
                      1'($urandom_range(0, 1)));
          end
          repeat ($urandom_range(2, 8)) begin
            if (rule_total > 0 && $urandom_range(0, 9) < 7) begin
              pick = $urandom_range(0, rule_total - 1);
              addr = rule_addr_m[pick] ^ ($urandom & ~top_bits_mask(rule_len_m[pick]));
            end else begin
              addr = $urandom;
            end
            send_item(($urandom_range(0, 9) == 0) ? CMD_QUERY_ALT : CMD_QUERY, addr,
                      6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
          end
        end else begin
          send_item(2'($urandom_range(0, 3)), $urandom, 6'($urandom_range(0, 63)),
                    1'($urandom_range(0, 1)));
        end
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_prefix_rules();
    test_full_table();
    test_random_traffic();
    drain_results();
    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("ipv4_first_match_acl_test: PASS");
    end else begin
      $display("ipv4_first_match_acl_test: FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("ipv4_first_match_acl_test: FAIL");
    $finish;
  end

endmodule
